[sv/seir_pkg.sv]
`default_nettype none

package seir_pkg;

  localparam int unsigned MEMBER_W = 7;
  localparam int unsigned STATE_W  = 3;
  localparam int unsigned RATE_W   = 32;
  localparam int unsigned COUNT_W  = 8;
  localparam int unsigned NSTATES  = 7;
  localparam int unsigned CFG_IDX_W = 3;

  // member state codes
  localparam logic [STATE_W-1:0] ST_SUS = 3'd0;
  localparam logic [STATE_W-1:0] ST_REC = 3'd1;
  localparam logic [STATE_W-1:0] ST_EXP = 3'd2;
  localparam logic [STATE_W-1:0] ST_IA1 = 3'd3;
  localparam logic [STATE_W-1:0] ST_IA2 = 3'd4;
  localparam logic [STATE_W-1:0] ST_ISS = 3'd5;
  localparam logic [STATE_W-1:0] ST_ISA = 3'd6;

  // item commands
  localparam logic CMD_ADVANCE = 1'b0;
  localparam logic CMD_LOAD    = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INFECT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ONSET   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ADVANCE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RECOVER = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SYMPTOM = 3'd4;

  localparam logic [RATE_W-1:0] INFECT_RST  = 32'd190887;
  localparam logic [RATE_W-1:0] ONSET_RST   = 32'd14316558;
  localparam logic [RATE_W-1:0] ADVANCE_RST = 32'd42949673;
  localparam logic [RATE_W-1:0] RECOVER_RST = 32'd6135668;
  localparam logic [RATE_W-1:0] SYMPTOM_RST = 32'd2319282340;

  typedef struct packed {
    logic                cmd;
    logic [MEMBER_W-1:0] member;
    logic [STATE_W-1:0]  load_state;
    logic [RATE_W-1:0]   draw;
    logic [RATE_W-1:0]   draw_split;
  } seir_in_t;

  typedef struct packed {
    logic [MEMBER_W-1:0] member_out;
    logic [STATE_W-1:0]  new_state;
    logic                changed;
    logic [COUNT_W-1:0]  count_susceptible;
    logic [COUNT_W-1:0]  count_recovered;
    logic [COUNT_W-1:0]  count_exposed;
    logic [COUNT_W-1:0]  count_early_asym;
    logic [COUNT_W-1:0]  count_late_asym;
    logic [COUNT_W-1:0]  count_symptomatic;
    logic [COUNT_W-1:0]  count_silent;
  } seir_out_t;

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic calc;
    logic commit;
  } seir_ctl_t;

endpackage

`default_nettype wire

[sv/seir_ram.sv]
`default_nettype none

module seir_ram #(
  parameter int unsigned WIDTH = 3,
  parameter int unsigned DEPTH = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[sv/seir_ctrl.sv]
`default_nettype none

module seir_ctrl
  import seir_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start,
  output logic      busy,
  output seir_ctl_t ctl_o
);

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_CALC,
    CS_COMMIT
  } ctl_state_e;

  ctl_state_e state_q;
  logic       busy_q;
  logic       accept;

  assign accept = start & ~busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
      busy_q  <= 1'b0;
    end else begin
      unique case (state_q)
        CS_IDLE: begin
          if (accept) begin
            state_q <= CS_CALC;
            busy_q  <= 1'b1;
          end
        end
        CS_CALC: begin
          state_q <= CS_COMMIT;
        end
        CS_COMMIT: begin
          state_q <= CS_IDLE;
          busy_q  <= 1'b0;
        end
        default: begin
          state_q <= CS_IDLE;
          busy_q  <= 1'b0;
        end
      endcase
    end
  end

  assign busy          = busy_q;
  assign ctl_o.capture = accept;
  assign ctl_o.calc    = (state_q == CS_CALC);
  assign ctl_o.commit  = (state_q == CS_COMMIT);

endmodule

`default_nettype wire

[sv/seir_dp.sv]
`default_nettype none

module seir_dp
  import seir_pkg::*;
#(
  parameter int unsigned MEMBERS = 128
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire seir_ctl_t            ctl_i,
  input  wire seir_in_t             item_i,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [RATE_W-1:0]    cfg_data_i,
  output logic                      done_o,
  output seir_out_t                 result_o
);

  localparam int unsigned SPAN  = 2 ** MEMBER_W;
  localparam int unsigned DEPTH = (MEMBERS < SPAN) ? MEMBERS : SPAN;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(MEMBERS + 1);
  localparam int unsigned INF_W = CNT_W + 2;
  localparam int unsigned PROD_W = RATE_W + INF_W;

  // configuration
  logic [RATE_W-1:0] infect_q, onset_q, advance_q, recover_q, symptom_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      infect_q  <= INFECT_RST;
      onset_q   <= ONSET_RST;
      advance_q <= ADVANCE_RST;
      recover_q <= RECOVER_RST;
      symptom_q <= SYMPTOM_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_INFECT:  infect_q  <= cfg_data_i;
        REG_ONSET:   onset_q   <= cfg_data_i;
        REG_ADVANCE: advance_q <= cfg_data_i;
        REG_RECOVER: recover_q <= cfg_data_i;
        REG_SYMPTOM: symptom_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // item capture
  seir_in_t             item_q;
  logic                 in_range_q;
  logic [STATE_W-1:0]   cur_q;
  logic [PROD_W-1:0]    prod_q;
  logic [CNT_W-1:0]     cnt_q [NSTATES];
  logic [CNT_W-1:0]     cnt_d [NSTATES];
  logic [DEPTH-1:0]     vld_q;
  logic [STATE_W-1:0]   ram_rdata;
  logic [AW-1:0]        addr_q;
  logic [INF_W-1:0]     inf_sum;
  logic [STATE_W-1:0]   next_st;
  logic                 move;

  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      item_q     <= item_i;
      in_range_q <= (32'(item_i.member) < 32'(MEMBERS));
      addr_q     <= item_i.member[AW-1:0];
    end
    if (ctl_i.calc) begin
      // never-written entries read as susceptible
      cur_q  <= vld_q[addr_q] ? ram_rdata : ST_SUS;
      prod_q <= PROD_W'(infect_q) * PROD_W'(inf_sum);
    end
  end

  assign inf_sum = INF_W'(cnt_q[ST_IA1]) + INF_W'(cnt_q[ST_IA2]) +
                   INF_W'(cnt_q[ST_ISS]) + INF_W'(cnt_q[ST_ISA]);

  seir_ram #(
    .WIDTH (STATE_W),
    .DEPTH (DEPTH)
  ) u_states (
    .clk_i   (clk_i),
    .we_i    (move),
    .waddr_i (addr_q),
    .wdata_i (next_st),
    .re_i    (ctl_i.capture),
    .raddr_i (item_i.member[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // transition
  always_comb begin
    next_st = cur_q;
    if (item_q.cmd == CMD_LOAD) begin
      if (item_q.load_state <= ST_ISA) begin
        next_st = item_q.load_state;
      end
    end else begin
      case (cur_q)
        ST_SUS: if (PROD_W'(item_q.draw) < prod_q) next_st = ST_EXP;
        ST_EXP: if (item_q.draw < onset_q) next_st = ST_IA1;
        ST_IA1: if (item_q.draw < advance_q) next_st = ST_IA2;
        ST_IA2: begin
          if (item_q.draw < advance_q) begin
            next_st = (item_q.draw_split < symptom_q) ? ST_ISS : ST_ISA;
          end
        end
        ST_ISS, ST_ISA: if (item_q.draw < recover_q) next_st = ST_REC;
        default: next_st = cur_q;
      endcase
    end
  end

  assign move = ctl_i.commit & in_range_q & (next_st != cur_q);

  always_comb begin
    for (int k = 0; k < NSTATES; k++) begin
      cnt_d[k] = cnt_q[k];
      if (move && (cur_q == STATE_W'(k)) && (cnt_q[k] != '0)) begin
        cnt_d[k] = cnt_q[k] - 1'b1;
      end
      if (move && (next_st == STATE_W'(k))) begin
        cnt_d[k] = cnt_q[k] + 1'b1;
      end
    end
  end

  logic                done_q;
  logic [MEMBER_W-1:0] member_q;
  logic [STATE_W-1:0]  new_state_q;
  logic                changed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      done_q <= 1'b0;
      for (int k = 0; k < NSTATES; k++) begin
        cnt_q[k] <= (STATE_W'(k) == ST_SUS) ? CNT_W'(MEMBERS) : '0;
      end
    end else begin
      done_q <= ctl_i.commit;
      if (move) begin
        vld_q[addr_q] <= 1'b1;
      end
      for (int k = 0; k < NSTATES; k++) begin
        cnt_q[k] <= cnt_d[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.commit) begin
      member_q    <= item_q.member;
      new_state_q <= in_range_q ? next_st : ST_SUS;
      changed_q   <= move;
    end
  end

  // counts reported modulo 256
  logic [CNT_W+COUNT_W-1:0] cnt_ext [NSTATES];

  always_comb begin
    for (int k = 0; k < NSTATES; k++) begin
      cnt_ext[k] = {{COUNT_W{1'b0}}, cnt_q[k]};
    end
  end

  assign done_o                     = done_q;
  assign result_o.member_out        = member_q;
  assign result_o.new_state         = new_state_q;
  assign result_o.changed           = changed_q;
  assign result_o.count_susceptible = cnt_ext[ST_SUS][COUNT_W-1:0];
  assign result_o.count_recovered   = cnt_ext[ST_REC][COUNT_W-1:0];
  assign result_o.count_exposed     = cnt_ext[ST_EXP][COUNT_W-1:0];
  assign result_o.count_early_asym  = cnt_ext[ST_IA1][COUNT_W-1:0];
  assign result_o.count_late_asym   = cnt_ext[ST_IA2][COUNT_W-1:0];
  assign result_o.count_symptomatic = cnt_ext[ST_ISS][COUNT_W-1:0];
  assign result_o.count_silent      = cnt_ext[ST_ISA][COUNT_W-1:0];

endmodule

`default_nettype wire

[sv/stochastic_seir_member_step.sv]
// Channel   Handshake              Payload
// item      start, busy            item_i   (seir_in_t)
// result    done_o (1-cycle pulse) result_o (seir_out_t)
// config    cfg_valid_i/ready_o    cfg_index_i, cfg_data_i
//
// Each item goes through capture and state-RAM read, infection product
// (one 32-by-10-bit multiply, registered), then commit. The result strobes in the
// cycle after commit, when the next item may already be taken.
// Reset marks every member susceptible through per-entry valid bits; no
// clearing pass. The result cannot be stalled; cfg_ready_o is always high.
`default_nettype none

module stochastic_seir_member_step
  import seir_pkg::*;
#(
  parameter int unsigned MEMBERS = 128
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start,
  output logic                      busy,
  input  wire seir_in_t             item_i,
  output logic                      done_o,
  output seir_out_t                 result_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [RATE_W-1:0]    cfg_data_i
);

  seir_ctl_t ctl;

  seir_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .ctl_o  (ctl)
  );

  seir_dp #(
    .MEMBERS (MEMBERS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .item_i      (item_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .done_o      (done_o),
    .result_o    (result_o)
  );

endmodule

`default_nettype wire

[sim/tb_stochastic_seir_member_step.sv]
`timescale 1ns / 100ps

module tb_stochastic_seir_member_step;
  import seir_pkg::*;

  localparam int unsigned POP         = 128;
  localparam int unsigned NREGS       = REG_SYMPTOM + 1;
  localparam int unsigned NPHASES     = 6;
  localparam int unsigned PHASE_ITEMS = 190;
  localparam int unsigned STALL_LIMIT = 1000;
  localparam logic [STATE_W-1:0] ST_BAD   = 3'd7;
  localparam logic [RATE_W-1:0]  RATE_MAX = 32'hFFFF_FFFF;

  typedef struct {
    seir_in_t  item;
    bit        typed;
    seir_out_t want;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  seir_in_t item_i = '0;
  logic done_o;
  seir_out_t result_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [RATE_W-1:0] cfg_data_i = '0;

  // shadow of the population and the rate registers
  logic [STATE_W-1:0] pop_state [POP];
  int unsigned pop_count [NSTATES];
  logic [RATE_W-1:0] rates [NREGS];

  seir_out_t awaited_updates [$];
  dir_row_t dir_rows [$];
  int unsigned entries_into [NSTATES];
  int unsigned n_items, n_loads, n_checked, n_errors, n_settings, idle_cycles;
  bit steady;

  stochastic_seir_member_step #(
    .MEMBERS(POP)
  ) uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start(start),
    .busy(busy),
    .item_i(item_i),
    .done_o(done_o),
    .result_o(result_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic flag_mismatch(input string msg);
    $display("[%0t] MISMATCH %s", $time, msg);
    n_errors++;
  endtask

  function automatic logic [63:0] infectious_total();
    return 64'(pop_count[ST_IA1]) + 64'(pop_count[ST_IA2]) + 64'(pop_count[ST_ISS]) +
           64'(pop_count[ST_ISA]);
  endfunction

  function automatic seir_out_t advance_population(input seir_in_t it);
    seir_out_t r;
    logic [STATE_W-1:0] cur;
    logic [STATE_W-1:0] nxt;
    logic [63:0] exposure;
    cur = pop_state[it.member];
    nxt = cur;
    if (it.cmd == CMD_LOAD) begin
      if (it.load_state != ST_BAD) nxt = it.load_state;
    end else begin
      case (cur)
        ST_SUS: begin
          exposure = 64'(rates[REG_INFECT]) * infectious_total();
          if (64'(it.draw) < exposure) nxt = ST_EXP;
        end
        ST_EXP: if (it.draw < rates[REG_ONSET]) nxt = ST_IA1;
        ST_IA1: if (it.draw < rates[REG_ADVANCE]) nxt = ST_IA2;
        ST_IA2: begin
          if (it.draw < rates[REG_ADVANCE])
            nxt = (it.draw_split < rates[REG_SYMPTOM]) ? ST_ISS : ST_ISA;
        end
        ST_ISS, ST_ISA: if (it.draw < rates[REG_RECOVER]) nxt = ST_REC;
        default: ;
      endcase
    end
    r.member_out = it.member;
    r.new_state  = nxt;
    r.changed    = (nxt != cur);
    if (r.changed) begin
      if (pop_count[cur] != 0) pop_count[cur]--;
      pop_count[nxt]++;
      pop_state[it.member] = nxt;
      entries_into[nxt]++;
    end
    r.count_susceptible = COUNT_W'(pop_count[ST_SUS]);
    r.count_recovered   = COUNT_W'(pop_count[ST_REC]);
    r.count_exposed     = COUNT_W'(pop_count[ST_EXP]);
    r.count_early_asym  = COUNT_W'(pop_count[ST_IA1]);
    r.count_late_asym   = COUNT_W'(pop_count[ST_IA2]);
    r.count_symptomatic = COUNT_W'(pop_count[ST_ISS]);
    r.count_silent      = COUNT_W'(pop_count[ST_ISA]);
    return r;
  endfunction

  // Random item; draws are steered onto and just below the threshold that
  // applies to the member's present state so both sides of each test get hit.
  function automatic seir_in_t random_item();
    seir_in_t it;
    logic [63:0] thr;
    int unsigned pick;
    it.cmd = ($urandom_range(0, 99) < 15) ? CMD_LOAD : CMD_ADVANCE;
    it.member = ($urandom_range(0, 9) < 7) ? MEMBER_W'($urandom_range(0, 15))
                                           : MEMBER_W'($urandom);
    it.load_state = STATE_W'($urandom);
    case (pop_state[it.member])
      ST_SUS:         thr = 64'(rates[REG_INFECT]) * infectious_total();
      ST_EXP:         thr = 64'(rates[REG_ONSET]);
      ST_IA1, ST_IA2: thr = 64'(rates[REG_ADVANCE]);
      ST_ISS, ST_ISA: thr = 64'(rates[REG_RECOVER]);
      default:        thr = '0;
    endcase
    if (thr > 64'(RATE_MAX)) thr = 64'(RATE_MAX);
    pick = $urandom_range(0, 9);
    case (pick)
      0:       it.draw = '0;
      1:       it.draw = RATE_MAX;
      2, 3:    it.draw = thr[31:0] - 32'($urandom_range(0, 1));
      4, 5:    it.draw = (thr == 0) ? '0 : 32'($urandom_range(0, thr[31:0] - 1));
      default: it.draw = $urandom;
    endcase
    pick = $urandom_range(0, 7);
    case (pick)
      0:       it.draw_split = '0;
      1:       it.draw_split = RATE_MAX;
      2, 3:    it.draw_split = rates[REG_SYMPTOM] - 32'($urandom_range(0, 1));
      default: it.draw_split = $urandom;
    endcase
    return it;
  endfunction

  function automatic seir_in_t mk_item(input logic c, input int unsigned m,
                                       input logic [STATE_W-1:0] ld,
                                       input logic [RATE_W-1:0] d,
                                       input logic [RATE_W-1:0] sp);
    seir_in_t it;
    it.cmd        = c;
    it.member     = MEMBER_W'(m);
    it.load_state = ld;
    it.draw       = d;
    it.draw_split = sp;
    return it;
  endfunction

  function automatic seir_out_t mk_want(input int unsigned m, input logic [STATE_W-1:0] st,
                                        input logic chg, input int unsigned s,
                                        input int unsigned rc, input int unsigned e,
                                        input int unsigned a1, input int unsigned a2,
                                        input int unsigned ss, input int unsigned sa);
    seir_out_t r;
    r.member_out        = MEMBER_W'(m);
    r.new_state         = st;
    r.changed           = chg;
    r.count_susceptible = COUNT_W'(s);
    r.count_recovered   = COUNT_W'(rc);
    r.count_exposed     = COUNT_W'(e);
    r.count_early_asym  = COUNT_W'(a1);
    r.count_late_asym   = COUNT_W'(a2);
    r.count_symptomatic = COUNT_W'(ss);
    r.count_silent      = COUNT_W'(sa);
    return r;
  endfunction

  function automatic void add_row(input seir_in_t it, input bit typed, input seir_out_t want);
    dir_row_t row;
    row.item  = it;
    row.typed = typed;
    row.want  = want;
    dir_rows.push_back(row);
  endfunction

  // start is left high on return so back-to-back items need not toggle it
  task automatic send_item(input seir_in_t it, input bit typed, input seir_out_t want);
    seir_out_t predicted;
    while (!steady && $urandom_range(0, 99) < 19) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start  <= 1'b1;
    item_i <= it;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predicted = advance_population(it);
    awaited_updates.push_back(typed ? want : predicted);
    n_items++;
    if (it.cmd == CMD_LOAD) n_loads++;
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk_i); while (awaited_updates.size() != 0);
  endtask

  task automatic write_rate(input logic [CFG_IDX_W-1:0] idx, input logic [RATE_W-1:0] val);
    while ($urandom_range(0, 99) < 19) begin
      cfg_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    rates[idx] = val;
  endtask

  task automatic set_rates(input int unsigned phase);
    logic [RATE_W-1:0] v [NREGS];
    case (phase)
      1: foreach (v[i]) v[i] = '0;
      2: foreach (v[i]) v[i] = RATE_MAX;
      3: begin
        // brisk flow through the chain, modest infection pressure
        v[REG_INFECT]  = 32'($urandom_range(0, 32'h0400_0000));
        v[REG_ONSET]   = 32'($urandom_range(32'h1000_0000, 32'h8000_0000));
        v[REG_ADVANCE] = 32'($urandom_range(32'h1000_0000, 32'h8000_0000));
        v[REG_RECOVER] = 32'($urandom_range(32'h1000_0000, 32'h8000_0000));
        v[REG_SYMPTOM] = $urandom;
      end
      4: foreach (v[i]) v[i] = $urandom;
      default: begin
        v[REG_INFECT]  = INFECT_RST;
        v[REG_ONSET]   = ONSET_RST;
        v[REG_ADVANCE] = ADVANCE_RST;
        v[REG_RECOVER] = RECOVER_RST;
        v[REG_SYMPTOM] = SYMPTOM_RST;
      end
    endcase
    drain();
    write_rate(REG_INFECT, v[REG_INFECT]);
    write_rate(REG_ONSET, v[REG_ONSET]);
    write_rate(REG_ADVANCE, v[REG_ADVANCE]);
    write_rate(REG_RECOVER, v[REG_RECOVER]);
    write_rate(REG_SYMPTOM, v[REG_SYMPTOM]);
    cfg_valid_i <= 1'b0;
    n_settings++;
  endtask

  // result checker
  always @(posedge clk_i) begin
    seir_out_t want;
    if (rst_ni && done_o) begin
      if (awaited_updates.size() == 0) begin
        flag_mismatch($sformatf("unexpected result for member %0d", result_o.member_out));
      end else begin
        want = awaited_updates.pop_front();
        n_checked++;
        if (result_o.member_out !== want.member_out)
          flag_mismatch($sformatf("member_out got %0d want %0d",
                                  result_o.member_out, want.member_out));
        if (result_o.new_state !== want.new_state)
          flag_mismatch($sformatf("member %0d new_state got %0d want %0d",
                                  want.member_out, result_o.new_state, want.new_state));
        if (result_o.changed !== want.changed)
          flag_mismatch($sformatf("member %0d changed got %0d want %0d",
                                  want.member_out, result_o.changed, want.changed));
        if (result_o.count_susceptible !== want.count_susceptible)
          flag_mismatch($sformatf("count_susceptible got %0d want %0d",
                                  result_o.count_susceptible, want.count_susceptible));
        if (result_o.count_recovered !== want.count_recovered)
          flag_mismatch($sformatf("count_recovered got %0d want %0d",
                                  result_o.count_recovered, want.count_recovered));
        if (result_o.count_exposed !== want.count_exposed)
          flag_mismatch($sformatf("count_exposed got %0d want %0d",
                                  result_o.count_exposed, want.count_exposed));
        if (result_o.count_early_asym !== want.count_early_asym)
          flag_mismatch($sformatf("count_early_asym got %0d want %0d",
                                  result_o.count_early_asym, want.count_early_asym));
        if (result_o.count_late_asym !== want.count_late_asym)
          flag_mismatch($sformatf("count_late_asym got %0d want %0d",
                                  result_o.count_late_asym, want.count_late_asym));
        if (result_o.count_symptomatic !== want.count_symptomatic)
          flag_mismatch($sformatf("count_symptomatic got %0d want %0d",
                                  result_o.count_symptomatic, want.count_symptomatic));
        if (result_o.count_silent !== want.count_silent)
          flag_mismatch($sformatf("count_silent got %0d want %0d",
                                  result_o.count_silent, want.count_silent));
      end
    end
  end

  // watchdog: cycles without any handshake on any channel
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o || (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    foreach (pop_state[i]) pop_state[i] = ST_SUS;
    foreach (pop_count[i]) pop_count[i] = 0;
    foreach (entries_into[i]) entries_into[i] = 0;
    pop_count[ST_SUS] = POP;
    rates[REG_INFECT]  = INFECT_RST;
    rates[REG_ONSET]   = ONSET_RST;
    rates[REG_ADVANCE] = ADVANCE_RST;
    rates[REG_RECOVER] = RECOVER_RST;
    rates[REG_SYMPTOM] = SYMPTOM_RST;
    idle_cycles = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // no infectious members yet, so a susceptible cannot be infected even at draw 0
    add_row(mk_item(CMD_ADVANCE, 0, ST_SUS, '0, '0), 1'b1,
            mk_want(0, ST_SUS, 1'b0, 128, 0, 0, 0, 0, 0, 0));
    // invalid load value leaves the member alone
    add_row(mk_item(CMD_LOAD, 5, ST_BAD, '0, '0), 1'b1,
            mk_want(5, ST_SUS, 1'b0, 128, 0, 0, 0, 0, 0, 0));
    add_row(mk_item(CMD_LOAD, 127, ST_ISS, RATE_MAX, RATE_MAX), 1'b1,
            mk_want(127, ST_ISS, 1'b1, 127, 0, 0, 0, 0, 1, 0));
    add_row(mk_item(CMD_LOAD, 0, ST_EXP, '0, '0), 1'b1,
            mk_want(0, ST_EXP, 1'b1, 126, 0, 1, 0, 0, 1, 0));
    add_row(mk_item(CMD_ADVANCE, 0, ST_SUS, '0, '0), 1'b1,
            mk_want(0, ST_IA1, 1'b1, 126, 0, 0, 1, 0, 1, 0));
    add_row(mk_item(CMD_ADVANCE, 0, ST_SUS, RATE_MAX, RATE_MAX), 1'b1,
            mk_want(0, ST_IA1, 1'b0, 126, 0, 0, 1, 0, 1, 0));
    add_row(mk_item(CMD_ADVANCE, 0, ST_SUS, '0, '0), 1'b1,
            mk_want(0, ST_IA2, 1'b1, 126, 0, 0, 0, 1, 1, 0));
    add_row(mk_item(CMD_ADVANCE, 0, ST_SUS, '0, '0), 1'b1,
            mk_want(0, ST_ISS, 1'b1, 126, 0, 0, 0, 0, 2, 0));
    add_row(mk_item(CMD_LOAD, 1, ST_IA2, RATE_MAX, RATE_MAX), 1'b0, '0);
    add_row(mk_item(CMD_ADVANCE, 1, ST_SUS, '0, RATE_MAX), 1'b0, '0);
    // threshold is strict: draw equal to the rate must not move
    add_row(mk_item(CMD_ADVANCE, 127, ST_SUS, RECOVER_RST, '0), 1'b0, '0);
    add_row(mk_item(CMD_ADVANCE, 127, ST_SUS, RECOVER_RST - 1, '0), 1'b0, '0);
    add_row(mk_item(CMD_ADVANCE, 127, ST_SUS, '0, '0), 1'b0, '0);
    add_row(mk_item(CMD_ADVANCE, 2, ST_SUS, '0, '0), 1'b0, '0);
    add_row(mk_item(CMD_ADVANCE, 2, ST_SUS, ONSET_RST, '0), 1'b0, '0);
    add_row(mk_item(CMD_ADVANCE, 2, ST_SUS, ONSET_RST - 1, '0), 1'b0, '0);
    add_row(mk_item(CMD_ADVANCE, 2, ST_SUS, ADVANCE_RST, '0), 1'b0, '0);
    add_row(mk_item(CMD_ADVANCE, 2, ST_SUS, ADVANCE_RST - 1, '0), 1'b0, '0);
    add_row(mk_item(CMD_ADVANCE, 2, ST_SUS, '0, SYMPTOM_RST), 1'b0, '0);
    add_row(mk_item(CMD_ADVANCE, 3, ST_SUS, RATE_MAX, '0), 1'b0, '0);
    // reloading the same state is a no-op
    add_row(mk_item(CMD_LOAD, 3, ST_SUS, '0, '0), 1'b0, '0);
    add_row(mk_item(CMD_LOAD, 0, ST_BAD, RATE_MAX, RATE_MAX), 1'b0, '0);
    add_row(mk_item(CMD_LOAD, 126, ST_REC, '0, '0), 1'b0, '0);
    add_row(mk_item(CMD_LOAD, 126, ST_IA1, '0, '0), 1'b0, '0);
    add_row(mk_item(CMD_LOAD, 127, ST_ISA, '0, '0), 1'b0, '0);

    foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);

    for (int unsigned phase = 0; phase < NPHASES; phase++) begin
      if (phase != 0) set_rates(phase);
      steady = (phase == 2);
      for (int unsigned k = 0; k < PHASE_ITEMS; k++) begin
        send_item(random_item(), 1'b0, '0);
        if ($urandom_range(0, 199) == 0) drain();
      end
    end

    drain();
    repeat (8) @(posedge clk_i);

    $display("Sent %0d items (%0d loads) under %0d rate settings plus reset values;",
             n_items, n_loads, n_settings);
    $display("%0d results compared", n_checked);
    $display("Entries per state: S %0d R %0d E %0d Ia1 %0d Ia2 %0d Iss %0d Isa %0d",
             entries_into[ST_SUS], entries_into[ST_REC], entries_into[ST_EXP],
             entries_into[ST_IA1], entries_into[ST_IA2], entries_into[ST_ISS],
             entries_into[ST_ISA]);
    if (awaited_updates.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", awaited_updates.size()));
    if (n_errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

[files.f]
sv/seir_pkg.sv
sv/seir_ram.sv
sv/seir_ctrl.sv
sv/seir_dp.sv
sv/stochastic_seir_member_step.sv
sim/tb_stochastic_seir_member_step.sv
